// ===== hw/rtl/tct_pkg.sv =====
`default_nettype none
package tct_pkg;

    localparam int CIRCUITS = 32;
    localparam int IDX_W    = (CIRCUITS > 1) ? $clog2(CIRCUITS) : 1;
    localparam int CNT_W    = $clog2(CIRCUITS + 1);

    localparam int REQ_W    = 2;
    localparam int FIELD_W  = 8;
    localparam int ADDR_W   = 56;
    localparam int PEER_W   = 2 * FIELD_W + 2 * ADDR_W;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_GET   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_MATCH = 2'd3;

    typedef struct packed {
        logic load;
        logic short_op;
        logic scan;
    } t_cmd;

    typedef struct packed {
        logic is_short;
        logic scan_done;
    } t_sts;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] index;
        logic [FIELD_W-1:0] id;
    } t_result;

endpackage
`default_nettype wire

// ===== hw/rtl/tct_ctrl.sv =====
`default_nettype none
module tct_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  wire            i_out_free,
    input  tct_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output tct_pkg::t_cmd  o_cmd,
    output logic           o_emit
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_emit         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.is_short) begin
                    o_cmd.short_op = 1'b1;
                    n_state        = ST_HOLD;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (i_out_free) begin
                    o_emit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tct_datapath.sv =====
`default_nettype none
module tct_datapath (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  tct_pkg::t_cmd                      i_cmd,
    input  wire  [tct_pkg::REQ_W-1:0]          i_req_type,
    input  wire  [tct_pkg::FIELD_W-1:0]        i_circuit_index,
    input  wire  [tct_pkg::FIELD_W-1:0]        i_circuit_id,
    input  wire  [tct_pkg::ADDR_W-1:0]         i_user_address,
    input  wire  [tct_pkg::ADDR_W-1:0]         i_node_address,
    output tct_pkg::t_sts                      o_sts,
    output tct_pkg::t_result                   o_result
);

    logic [tct_pkg::REQ_W-1:0]    r_req;
    logic [tct_pkg::FIELD_W-1:0]  r_idx;
    logic [tct_pkg::FIELD_W-1:0]  r_cid;
    logic [tct_pkg::ADDR_W-1:0]   r_user;
    logic [tct_pkg::ADDR_W-1:0]   r_node;

    logic [tct_pkg::CIRCUITS-1:0] r_valid;
    logic [tct_pkg::FIELD_W-1:0]  r_serial [tct_pkg::CIRCUITS];

    logic [tct_pkg::CNT_W-1:0]    r_cnt;
    logic                         r_rd_vld;
    logic [tct_pkg::IDX_W-1:0]    r_rd_idx;

    logic [tct_pkg::PEER_W-1:0]   r_mem [tct_pkg::CIRCUITS];
    logic [tct_pkg::PEER_W-1:0]   r_rd_data;

    tct_pkg::t_result             r_res;

    logic [tct_pkg::PEER_W-1:0]   peer;
    logic                         in_range;
    logic [tct_pkg::IDX_W-1:0]    sel;
    logic [tct_pkg::FIELD_W-1:0]  sel_next_serial;
    logic                         get_ok;
    logic                         hit;
    logic                         last;
    logic                         scan_done;
    logic                         issue;
    logic                         mem_we;

    assign peer            = {r_node, r_user, r_cid, r_idx};
    assign in_range        = {1'b0, r_idx} < 9'(tct_pkg::CIRCUITS);
    assign sel             = r_idx[tct_pkg::IDX_W-1:0];
    assign sel_next_serial = r_serial[sel] + 8'd1;
    assign get_ok          = in_range && r_valid[sel] && (r_serial[sel] == r_cid);

    assign hit  = r_rd_vld && ((r_req == tct_pkg::REQ_ALLOC) ? !r_valid[r_rd_idx]
                  : (r_valid[r_rd_idx] && (r_rd_data == peer)));
    assign last      = r_rd_idx == tct_pkg::IDX_W'(tct_pkg::CIRCUITS - 1);
    assign scan_done = r_rd_vld && (hit || last);
    assign issue     = r_cnt < tct_pkg::CNT_W'(tct_pkg::CIRCUITS);
    assign mem_we    = i_cmd.scan && hit && (r_req == tct_pkg::REQ_ALLOC);

    assign o_sts.is_short  = (r_req == tct_pkg::REQ_FREE) || (r_req == tct_pkg::REQ_GET);
    assign o_sts.scan_done = scan_done;
    assign o_result        = r_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req_type;
            r_idx  <= i_circuit_index;
            r_cid  <= i_circuit_id;
            r_user <= i_user_address;
            r_node <= i_node_address;
        end
        if (i_cmd.scan && scan_done) begin
            if (hit) begin
                r_res.found <= 1'b1;
                r_res.index <= 8'(r_rd_idx);
                r_res.id    <= r_serial[r_rd_idx];
            end else begin
                r_res <= '0;
            end
        end
        if (i_cmd.short_op) begin
            if (r_req == tct_pkg::REQ_FREE) begin
                r_res.found <= in_range;
                r_res.index <= in_range ? r_idx : 8'd0;
                r_res.id    <= in_range ? sel_next_serial : 8'd0;
            end else begin
                r_res.found <= get_ok;
                r_res.index <= get_ok ? r_idx : 8'd0;
                r_res.id    <= get_ok ? r_serial[sel] : 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            for (int i = 0; i < tct_pkg::CIRCUITS; i++) begin
                r_serial[i] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_cnt    <= '0;
                r_rd_vld <= 1'b0;
            end
            if (i_cmd.scan) begin
                if (issue && !scan_done) begin
                    r_cnt    <= r_cnt + 1'b1;
                    r_rd_vld <= 1'b1;
                    r_rd_idx <= r_cnt[tct_pkg::IDX_W-1:0];
                end else begin
                    r_rd_vld <= 1'b0;
                end
                if (mem_we) begin
                    r_valid[r_rd_idx] <= 1'b1;
                end
            end
            if (i_cmd.short_op && (r_req == tct_pkg::REQ_FREE) && in_range) begin
                r_valid[sel]  <= 1'b0;
                r_serial[sel] <= sel_next_serial;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_rd_idx] <= peer;
        end
        if (i_cmd.scan) begin
            r_rd_data <= r_mem[r_cnt[tct_pkg::IDX_W-1:0]];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/transport_circuit_table.sv =====
// Circuit table with 32 entries. Each request on the slave stream is one of allocate, free,
// get or match, and gives exactly one response on the master stream. Free and get register the
// request on acceptance, work out the result in the execute state and then pass it to the
// output register. Allocate and match walk the table one entry per cycle through a single
// registered read port of the peer store and stop at the first fitting entry, so they end
// sooner when the wanted entry sits low. One request is in work at a time; a new request is
// taken while the previous response still waits in the output register, and a finished
// request holds in its last cycle until that register frees.
`default_nettype none
module transport_circuit_table (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [127:0] i_s_tdata,  // circuit_index[7:0], circuit_id[15:8],
                                     // user_address[71:16], node_address[127:72]
    input  wire  [1:0]   i_s_tuser,  // req_type[1:0]
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [15:0]  o_m_tdata,  // result_index[7:0], result_id[15:8]
    output logic [0:0]   o_m_tuser   // found[0]
);

    tct_pkg::t_cmd    cmd;
    tct_pkg::t_sts    sts;
    tct_pkg::t_result result;
    logic             emit;
    logic             out_free;

    logic             r_out_vld;
    tct_pkg::t_result r_out_res;

    assign out_free = !r_out_vld || i_m_tready;

    tct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd),
        .o_emit     (emit)
    );

    tct_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_req_type      (i_s_tuser),
        .i_circuit_index (i_s_tdata[7:0]),
        .i_circuit_id    (i_s_tdata[15:8]),
        .i_user_address  (i_s_tdata[71:16]),
        .i_node_address  (i_s_tdata[127:72]),
        .o_sts           (sts),
        .o_result        (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_res <= result;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_res.id, r_out_res.index};
    assign o_m_tuser  = r_out_res.found;

endmodule
`default_nettype wire
